### hw/rtl/w2a_pkg.sv
// Package for the word to decimal/hex ASCII converter.
// Holds the item types, the cell and controller codes and the digit-to-ASCII function.
// No dependencies.
`timescale 1ns / 1ps

package w2a_pkg;

  localparam int VALUE_W   = 16;
  localparam int DIGIT_W   = 4;
  localparam int NUM_CELLS = 5;
  localparam int HEX_DIGITS = 4;
  localparam int POS_W     = 8;
  localparam int CHAR_W    = 7;
  localparam int CNT_W     = 3;
  localparam int BIT_CNT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;

  localparam logic                 ACT_DEC = 1'b0;
  localparam logic                 ACT_HEX = 1'b1;

  // Decimal digit weights used to find the printed length.
  localparam logic [VALUE_W-1:0] W_10    = 16'd10;
  localparam logic [VALUE_W-1:0] W_100   = 16'd100;
  localparam logic [VALUE_W-1:0] W_1000  = 16'd1000;
  localparam logic [VALUE_W-1:0] W_10000 = 16'd10000;

  typedef struct packed {
    logic              action;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]  start_length;
    logic [POS_W-1:0]  max_length;
  } in_item_t;

  typedef struct packed {
    logic              char_valid;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  final_length;
    logic              last;
  } out_item_t;

  // Operation applied to every cell of the digit chain in the same cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // Map a digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] nib,
                                                 input logic lower);
    logic [CHAR_W-1:0] base;
    base = lower ? CHAR_LOWER : CHAR_UPPER;
    if (nib < 4'd10) begin
      return CHAR_ZERO + {3'b000, nib};
    end
    return base + {3'b000, nib} - 7'd10;
  endfunction

endpackage

### hw/rtl/word_to_decimal_hex_ascii_core.sv
// Top level of the word to decimal/hex ASCII converter: controller, digit chain, result register.
// Depends on w2a_pkg and w2a_cell.
//
// Channel  Ports                             Handshake
// input    start, busy, in_item              taken when start is high and busy is low
// result   out_strobe, out_item              shown for a single cycle each, cannot be held off
// config   cfg_valid, cfg_ready, cfg_data    written when cfg_valid and cfg_ready are high
//
// Hex items are loaded, then give one character per cycle; a no-room item gives an empty result.
// Decimal items are loaded, then take one shift-and-add-3 step per value bit through the five
// digit cells, then drop one leading zero digit per cycle, then give one character per cycle.
// Results are registered and leave in the next cycle; busy is low again as the last one leaves.
// Reset is synchronous and clears the controller, the result strobe and hex_lower_r.
// The receiver cannot stall; every result is shown for exactly one cycle.
`timescale 1ns / 1ps

module word_to_decimal_hex_ascii_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  w2a_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output w2a_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import w2a_pkg::*;

  state_t                 state_r, state_nxt;
  logic                   hex_lower_r;
  logic                   hex_r, hex_nxt;
  logic [VALUE_W-1:0]     value_r, value_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]       skip_r, skip_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [POS_W-1:0]       fin_r, fin_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  out_item_t              out_item_r, out_item_nxt;

  cell_op_t               cell_op;
  logic [DIGIT_W-1:0]     load_digit [NUM_CELLS];
  logic [DIGIT_W-1:0]     cell_digit [NUM_CELLS];
  logic                   cell_bit   [NUM_CELLS+1];

  logic                   accept;
  logic [CNT_W-1:0]       dec_len;
  logic [CNT_W-1:0]       ndig;
  logic [POS_W-1:0]       room;
  logic [CNT_W-1:0]       count;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_lower_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      hex_lower_r <= cfg_data;
    end
  end

  // Printed decimal length, and how many characters fit before the limit.
  always_comb begin
    if (in_item.value >= W_10000) begin
      dec_len = 3'd5;
    end else if (in_item.value >= W_1000) begin
      dec_len = 3'd4;
    end else if (in_item.value >= W_100) begin
      dec_len = 3'd3;
    end else if (in_item.value >= W_10) begin
      dec_len = 3'd2;
    end else begin
      dec_len = 3'd1;
    end
    ndig  = (in_item.action == ACT_HEX) ? CNT_W'(HEX_DIGITS) : dec_len;
    room  = (in_item.start_length < in_item.max_length) ?
            in_item.max_length - in_item.start_length : '0;
    count = (room < {5'b00000, ndig}) ? room[CNT_W-1:0] : ndig;
  end

  // Load values: hex puts the nibbles into the upper four cells, decimal clears the chain.
  always_comb begin
    for (int k = 0; k < NUM_CELLS; k++) begin
      load_digit[k] = '0;
    end
    if (in_item.action == ACT_HEX) begin
      for (int k = 1; k < NUM_CELLS; k++) begin
        load_digit[k] = in_item.value[(k-1)*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Digit chain: bits ripple up during conversion, digits move up during output.
  assign cell_bit[0] = value_r[VALUE_W-1];

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    logic [DIGIT_W-1:0] digit_in;
    if (g == 0) begin : g_first
      assign digit_in = '0;
    end else begin : g_rest
      assign digit_in = cell_digit[g-1];
    end
    w2a_cell u_cell (
      .clk        (clk),
      .op         (cell_op),
      .load_digit (load_digit[g]),
      .bit_in     (cell_bit[g]),
      .digit_in   (digit_in),
      .digit      (cell_digit[g]),
      .bit_out    (cell_bit[g+1])
    );
  end

  // Controller state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Working registers and the result register carry no reset.
  always_ff @(posedge clk) begin
    hex_r      <= hex_nxt;
    value_r    <= value_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    skip_r     <= skip_nxt;
    cnt_r      <= cnt_nxt;
    pos_r      <= pos_nxt;
    fin_r      <= fin_nxt;
    out_item_r <= out_item_nxt;
  end

  // Next state, chain operation and result.
  always_comb begin
    state_nxt      = state_r;
    hex_nxt        = hex_r;
    value_nxt      = value_r;
    bit_cnt_nxt    = bit_cnt_r;
    skip_nxt       = skip_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    fin_nxt        = fin_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    cell_op        = CELL_HOLD;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hex_nxt     = in_item.action;
          value_nxt   = in_item.value;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_W - 1);
          skip_nxt    = CNT_W'(NUM_CELLS) - dec_len;
          cnt_nxt     = count;
          pos_nxt     = in_item.start_length;
          fin_nxt     = in_item.start_length + {5'b00000, count};
          cell_op     = CELL_LOAD;
          if (count == '0) begin
            // No room: one empty result, and the block stays free.
            out_strobe_nxt            = 1'b1;
            out_item_nxt.char_valid   = 1'b0;
            out_item_nxt.char_code    = '0;
            out_item_nxt.position     = in_item.start_length;
            out_item_nxt.final_length = in_item.start_length;
            out_item_nxt.last         = 1'b1;
          end else if (in_item.action == ACT_HEX) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        cell_op     = CELL_DABBLE;
        value_nxt   = {value_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == '0) begin
          state_nxt = (skip_r == '0) ? ST_EMIT : ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zero digits from the top of the chain.
        cell_op  = CELL_SHIFT;
        skip_nxt = skip_r - 1'b1;
        if (skip_r == 3'd1) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cell_op                   = CELL_SHIFT;
        out_strobe_nxt            = 1'b1;
        out_item_nxt.char_valid   = 1'b1;
        out_item_nxt.char_code    = hex_char(cell_digit[NUM_CELLS-1], hex_lower_r);
        out_item_nxt.position     = pos_r;
        out_item_nxt.final_length = fin_r;
        out_item_nxt.last         = (cnt_r == 3'd1);
        pos_nxt                   = pos_r + 1'b1;
        cnt_nxt                   = cnt_r - 1'b1;
        if (cnt_r == 3'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The results of one item leave in consecutive cycles.
  a_results_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_item_r.last |=> out_strobe_r)
    else $error("result sequence broken before its last result");

  // An empty result is always the only one of its item.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_item_r.char_valid |-> out_item_r.last)
    else $error("empty result not marked last");

  // The block frees itself only when the last result goes out.
  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe_r && out_item_r.last)
    else $error("busy dropped without a last result");

  // Decimal conversion leaves only valid digits at the top of the chain.
  a_dec_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && hex_r == ACT_DEC |-> cell_digit[NUM_CELLS-1] <= 4'd9)
    else $error("decimal digit out of range");

  // The last character's position is one below the final length.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_item_r.char_valid && out_item_r.last |->
      out_item_r.position + 8'd1 == out_item_r.final_length)
    else $error("last character position does not match final length");

endmodule

### hw/rtl/w2a_cell.sv
// One digit cell of the conversion chain: a 4-bit digit register.
// Depends on w2a_pkg for the cell operation codes.
`timescale 1ns / 1ps

module w2a_cell (
  input  logic                       clk,
  input  w2a_pkg::cell_op_t          op,
  input  logic [w2a_pkg::DIGIT_W-1:0] load_digit,
  input  logic                       bit_in,
  input  logic [w2a_pkg::DIGIT_W-1:0] digit_in,
  output logic [w2a_pkg::DIGIT_W-1:0] digit,
  output logic                       bit_out
);
  import w2a_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // Add three when the digit would overflow past nine after doubling.
  assign adj     = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign bit_out = adj[DIGIT_W-1];
  assign digit   = digit_r;

  // Next digit for each chain operation.
  always_comb begin
    case (op)
      CELL_LOAD:   digit_nxt = load_digit;
      CELL_DABBLE: digit_nxt = {adj[DIGIT_W-2:0], bit_in};
      CELL_SHIFT:  digit_nxt = digit_in;
      default:     digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule
